// File: sv/image_convolution_5x5_assert.svh
`ifndef IMAGE_CONVOLUTION_5X5_ASSERT_SVH
`define IMAGE_CONVOLUTION_5X5_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IC5_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("image_convolution_5x5 assertion failed");

// Next-cycle implication, checked out of reset.
`define IC5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("image_convolution_5x5 assertion failed");

`endif

// File: sv/imgconv5_pkg.sv
package imgconv5_pkg;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [2:0] CSR_COEF_ROW0      = 3'd0;
   localparam logic [2:0] CSR_COEF_ROW1      = 3'd1;
   localparam logic [2:0] CSR_COEF_ROW2      = 3'd2;
   localparam logic [2:0] CSR_COEF_ROW3      = 3'd3;
   localparam logic [2:0] CSR_COEF_ROW4      = 3'd4;
   localparam logic [2:0] CSR_FRAME_SIZE     = 3'd5;
   localparam logic [2:0] CSR_SCALE_AND_BIAS = 3'd6;
   localparam logic [2:0] CSR_MODE           = 3'd7;

   localparam int COEF_BITS = 55;

   typedef logic signed [10:0] weight_type;
   typedef logic [COEF_BITS-1:0] coef_row_type;

endpackage

// File: sv/imgconv5_ram.sv
module imgconv5_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/image_convolution_5x5.sv
// Channel   Direction  Transfer when          Payload
// req_      in         req_valid & req_ready  opcode, pixel_value
// rsp_      out        rsp_valid & rsp_ready  result_pixel, last_of_run, end_of_line,
//                                             end_of_frame
// csr_      in         csr_wr_en              index, write data
//
// One item is handled at a time; req_ready is high only while the sequencer is idle.
// An ignored item is taken without leaving idle. Any other item forms each result by
// 25 reads of the single read port of the row memory, a drain of the multiply-accumulate
// pipeline, then scale, bias and clamp. A pixel at the end of a row releases three results.
// Reset clears counters and flags and sets CSR defaults; row memory is not cleared.
// A full result register stalls the sequencer until the result is taken.
module image_convolution_5x5
   import imgconv5_pkg::*;
#(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [15:0] req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_pixel,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_line,
   output logic        rsp_end_of_frame,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int W_BITS    = COL_BITS + 1;
   localparam int DEPTH     = 5 * MAX_WIDTH;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int PROD_BITS = SAMPLE_BITS + 12;
   localparam int ACC_BITS  = SAMPLE_BITS + 17;
   localparam int SCL_BITS  = ACC_BITS + 33;
   localparam int SUM_BITS  = SCL_BITS + 1;
   localparam int Q_BITS    = SUM_BITS - 24;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TAPS  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   function automatic logic signed [17:0] mirror_idx(input logic signed [17:0] v,
                                                     input logic signed [17:0] n);
      logic signed [17:0] a;
      begin
         a = (v < 0) ? -v : v;
         if (a >= n) a = 18'sd2 * (n - 18'sd1) - a;
         if (a < 0) a = '0;
         if (a > n - 18'sd1) a = n - 18'sd1;
         return a;
      end
   endfunction

   coef_row_type          coef_ff [5];
   coef_row_type          coef_in [5];
   logic [31:0]           frame_size_ff, frame_size_in;
   logic [63:0]           scale_bias_ff, scale_bias_in;
   logic [1:0]            mode_ff, mode_in;

   logic [2:0]            state_ff, state_in;
   logic                  op_ff, op_in;
   logic [1:0]            rem_ff, rem_in;
   logic [COL_BITS-1:0]   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [15:0]           in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [2:0]            base_ff, base_in;
   logic [2:0]            dy_ff, dy_in, dx_ff, dx_in;
   logic                  v1_ff, v1_in, v2_ff, v2_in;
   weight_type            w1_ff, w1_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [SCL_BITS-1:0]  scaled_ff, scaled_in;
   logic signed [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_last_ff, rsp_last_in, rsp_eol_ff, rsp_eol_in;
   logic                  rsp_eof_ff, rsp_eof_in;

   logic [W_BITS-1:0]     w_val;
   logic [15:0]           h_val;
   logic                  in_eol, out_eol, out_last_row, out_free;
   logic signed [17:0]    row_m, col_m;
   logic [15:0]           row_diff;
   logic [2:0]            k3, kk, slot;
   logic [3:0]            slot_sum;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data, ram_rd_data;
   logic signed [SUM_BITS-1:0] adj;
   logic signed [Q_BITS-1:0]   q, maxv;

   imgconv5_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (frame_size_ff[15:0] < 16'd3) w_val = W_BITS'(3);
      else if (frame_size_ff[15:0] > 16'(MAX_WIDTH)) w_val = W_BITS'(MAX_WIDTH);
      else w_val = frame_size_ff[W_BITS-1:0];
      h_val = (frame_size_ff[31:16] < 16'd3) ? 16'd3 : frame_size_ff[31:16];
   end

   assign in_eol       = (W_BITS'(in_col_ff) + W_BITS'(1)) >= w_val;
   assign out_eol      = (W_BITS'(out_col_ff) + W_BITS'(1)) >= w_val;
   assign out_last_row = ({1'b0, out_row_ff} + 17'd1) >= {1'b0, h_val};
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);

   always_comb begin
      row_m = mirror_idx($signed({2'b0, out_row_ff}) + $signed({15'b0, dy_ff}) - 18'sd2,
                         $signed({2'b0, h_val}));
      col_m = mirror_idx($signed({{(18-COL_BITS){1'b0}}, out_col_ff})
                         + $signed({15'b0, dx_ff}) - 18'sd2,
                         $signed({{(18-W_BITS){1'b0}}, w_val}));
      row_diff = in_row_ff - row_m[15:0];
      k3       = row_diff[2:0];
      kk       = (k3 > 3'd4) ? k3 - 3'd5 : k3;
      slot_sum = {1'b0, base_ff} + 4'd5 - {1'b0, kk};
      slot     = (slot_sum >= 4'd5) ? 3'(slot_sum - 4'd5) : slot_sum[2:0];
      ram_rd_addr = ADDR_BITS'(slot) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col_m[COL_BITS-1:0]);
      ram_wr_addr = ADDR_BITS'(base_ff) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(in_col_ff);
      ram_wr_data = mode_ff[1] ? req_pixel_value[SAMPLE_BITS-1:0]
                               : SAMPLE_BITS'(req_pixel_value[7:0]);
   end

   always_comb begin
      adj  = sum_ff[SUM_BITS-1] ? sum_ff + SUM_BITS'(24'hFFFFFF) : sum_ff;
      q    = adj[SUM_BITS-1:24];
      maxv = mode_ff[1] ? Q_BITS'((32'd1 << SAMPLE_BITS) - 32'd1) : Q_BITS'(255);
      if (!mode_ff[0] && q < 0) q = -q;
      if (q < 0) q = '0;
      else if (q > maxv) q = maxv;
   end

   always_comb begin
      coef_in       = coef_ff;
      frame_size_in = frame_size_ff;
      scale_bias_in = scale_bias_ff;
      mode_in       = mode_ff;
      state_in      = state_ff;
      op_in         = op_ff;
      rem_in        = rem_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      base_in       = base_ff;
      dy_in         = dy_ff;
      dx_in         = dx_ff;
      v1_in         = 1'b0;
      v2_in         = v1_ff;
      w1_in         = w1_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      scaled_in     = scaled_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_eol_in    = rsp_eol_ff;
      rsp_eof_in    = rsp_eof_ff;
      ram_wr_en     = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_ROW0:      coef_in[0] = csr_wr_data[COEF_BITS-1:0];
            CSR_COEF_ROW1:      coef_in[1] = csr_wr_data[COEF_BITS-1:0];
            CSR_COEF_ROW2:      coef_in[2] = csr_wr_data[COEF_BITS-1:0];
            CSR_COEF_ROW3:      coef_in[3] = csr_wr_data[COEF_BITS-1:0];
            CSR_COEF_ROW4:      coef_in[4] = csr_wr_data[COEF_BITS-1:0];
            CSR_FRAME_SIZE:     frame_size_in = csr_wr_data[31:0];
            CSR_SCALE_AND_BIAS: scale_bias_in = csr_wr_data;
            CSR_MODE:           mode_in = csr_wr_data[1:0];
            default:            mode_in = mode_ff;
         endcase
      end

      if (v1_ff) prod_in = $signed({1'b0, ram_rd_data}) * w1_ff;
      if (v2_ff) acc_in = acc_ff + {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

      unique case (state_ff)
         ST_IDLE: begin
            dy_in  = '0;
            dx_in  = '0;
            acc_in = '0;
            if (req_valid) begin
               op_in = req_opcode;
               if (req_opcode == OP_PIXEL) begin
                  if (in_row_ff < h_val) begin
                     ram_wr_en = (W_BITS'(in_col_ff) < w_val);
                     if (in_row_ff >= 16'd2 && in_col_ff >= COL_BITS'(2)) begin
                        rem_in   = in_eol ? 2'd3 : 2'd1;
                        state_in = ST_TAPS;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               end else if (in_row_ff >= h_val) begin
                  rem_in   = 2'd1;
                  state_in = ST_TAPS;
               end
            end
         end
         ST_TAPS: begin
            v1_in = 1'b1;
            w1_in = coef_ff[dy_ff][11*dx_ff +: 11];
            if (dx_ff == 3'd4) begin
               dx_in = '0;
               if (dy_ff == 3'd4) state_in = ST_DRAIN;
               else dy_in = dy_ff + 3'd1;
            end else begin
               dx_in = dx_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_MUL;
         end
         ST_MUL: begin
            scaled_in = $signed({{33{acc_ff[ACC_BITS-1]}}, acc_ff})
                      * $signed({{(ACC_BITS+1){1'b0}}, scale_bias_ff[31:0]});
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            sum_in = {scaled_ff[SCL_BITS-1], scaled_ff}
                   + $signed({{(SUM_BITS-48){scale_bias_ff[63]}}, scale_bias_ff[63:32], 16'b0})
                   + $signed(SUM_BITS'(24'h800000));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = q[15:0];
               rsp_last_in  = (rem_ff == 2'd1);
               rsp_eol_in   = out_eol;
               rsp_eof_in   = out_eol && out_last_row;
               if (out_eol) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 16'd1;
               end else begin
                  out_col_in = out_col_ff + COL_BITS'(1);
               end
               rem_in = rem_ff - 2'd1;
               dy_in  = '0;
               dx_in  = '0;
               acc_in = '0;
               state_in = (rem_ff == 2'd1) ? ST_DONE : ST_TAPS;
            end
         end
         ST_DONE: begin
            if (op_ff == OP_PIXEL) begin
               if (in_eol) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + 16'd1;
                  base_in   = (base_ff == 3'd4) ? 3'd0 : base_ff + 3'd1;
               end else begin
                  in_col_in = in_col_ff + COL_BITS'(1);
               end
            end
            if (out_row_ff >= h_val) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               base_in    = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]    <= '0;
         coef_ff[1]    <= '0;
         coef_ff[2]    <= COEF_BITS'(4194304);
         coef_ff[3]    <= '0;
         coef_ff[4]    <= '0;
         frame_size_ff <= 32'd196611;
         scale_bias_ff <= 64'd16777216;
         mode_ff       <= 2'd1;
         state_ff      <= ST_IDLE;
         rem_ff        <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         base_ff       <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         coef_ff       <= coef_in;
         frame_size_ff <= frame_size_in;
         scale_bias_ff <= scale_bias_in;
         mode_ff       <= mode_in;
         state_ff      <= state_in;
         rem_ff        <= rem_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         base_ff       <= base_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      dy_ff        <= dy_in;
      dx_ff        <= dx_in;
      w1_ff        <= w1_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      scaled_ff    <= scaled_in;
      sum_ff       <= sum_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_eol_ff   <= rsp_eol_in;
      rsp_eof_ff   <= rsp_eof_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_end_of_line  = rsp_eol_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// File: sv/imgconv5_checker.sv
`include "image_convolution_5x5_assert.svh"

module imgconv5_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_result_pixel,
   input logic        rsp_last_of_run,
   input logic        rsp_end_of_line,
   input logic        rsp_end_of_frame
);

   `IC5_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_pixel))
   `IC5_ASSERT_NOW(a_eof_ends_line, clock, reset, rsp_valid && rsp_end_of_frame, rsp_end_of_line)
   `IC5_ASSERT_NOW(a_eof_ends_run, clock, reset, rsp_valid && rsp_end_of_frame, rsp_last_of_run)

endmodule

bind image_convolution_5x5 imgconv5_checker u_imgconv5_checker (.*);
